// ===== rtl/core/sofif_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofif_pkg
// Shared types, constants and helpers for the second-order IIR filter.
// ----------------------------------------------------------------------------
package sofif_pkg;

   // Sample and coefficient formats: Q16.16 samples, Q2.30 coefficients
   localparam int SAMPLE_W    = 32;
   localparam int COEF_W      = 32;
   localparam int PROD_W      = SAMPLE_W + COEF_W;
   localparam int FRAC_SHIFT  = 30;
   localparam int CSR_INDEX_W = 3;

   // Default history depth
   localparam int FILTER_ORDER_DEF = 2;

   typedef logic signed [SAMPLE_W-1:0]  sample_type;
   typedef logic signed [COEF_W-1:0]    coef_word_type;
   typedef logic [CSR_INDEX_W-1:0]      csr_index_type;

   // Configuration register indexes
   localparam csr_index_type REG_B0 = 3'd0;
   localparam csr_index_type REG_B1 = 3'd1;
   localparam csr_index_type REG_B2 = 3'd2;
   localparam csr_index_type REG_A1 = 3'd3;
   localparam csr_index_type REG_A2 = 3'd4;

   localparam sample_type SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam sample_type SAMPLE_MIN = 32'sh8000_0000;

   typedef struct packed {
      coef_word_type b0;
      coef_word_type b1;
      coef_word_type b2;
      coef_word_type a1;
      coef_word_type a2;
   } coef_type;

   // Numerator coefficient for a tap; taps past the register set are zero
   function automatic coef_word_type tap_num(coef_type c, int tap);
      coef_word_type r;
      case (tap)
         0:       r = c.b0;
         1:       r = c.b1;
         2:       r = c.b2;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Denominator coefficient for a tap; the leading one is implied
   function automatic coef_word_type tap_den(coef_type c, int tap);
      coef_word_type r;
      case (tap)
         1:       r = c.a1;
         2:       r = c.a2;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/sofif_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofif_intf
// Valid/ready channels of the filter: sample in, sample out, register write.
// ----------------------------------------------------------------------------
interface sofif_req_if import sofif_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface sofif_rsp_if import sofif_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface sofif_csr_if import sofif_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   coef_word_type wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/sofif_coef_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofif_coef_regs
// Coefficient register file, written over the register write channel.
// ----------------------------------------------------------------------------
module sofif_coef_regs import sofif_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   sofif_csr_if.sink      csr_ch,
   output coef_type       coef
);

   coef_type coef_ff;
   coef_type coef_in;
   logic     csr_fire;

   // Always take a write; indexes past the list are dropped
   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid & csr_ch.ready;

   // Decode the write into the addressed coefficient
   always_comb begin
      coef_in = coef_ff;
      if (csr_fire) begin
         case (csr_ch.index)
            REG_B0:  coef_in.b0 = csr_ch.wdata;
            REG_B1:  coef_in.b1 = csr_ch.wdata;
            REG_B2:  coef_in.b2 = csr_ch.wdata;
            REG_A1:  coef_in.a1 = csr_ch.wdata;
            REG_A2:  coef_in.a2 = csr_ch.wdata;
            default: coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

// ===== rtl/core/sofif_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofif_mac
// One filter evaluation: parallel products, wide sum, round and saturate.
// ----------------------------------------------------------------------------
module sofif_mac import sofif_pkg::*; #(
   parameter int FILTER_ORDER = FILTER_ORDER_DEF
) (
   input  coef_type   coef,
   input  sample_type x,
   input  sample_type x_hist [FILTER_ORDER],
   input  sample_type y_hist [FILTER_ORDER],
   output sample_type y
);

   localparam int N_PROD = 2 * FILTER_ORDER + 1;
   // One extra bit for the rounding constant on top of the product count
   localparam int ACC_W  = PROD_W + $clog2(N_PROD + 1) + 1;
   localparam int RND_W  = ACC_W - FRAC_SHIFT;

   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      ACC_W'(64'sd1 <<< (FRAC_SHIFT - 1));
   localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(SAMPLE_MAX);
   localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(SAMPLE_MIN);

   logic signed [PROD_W-1:0] prod  [N_PROD];
   logic signed [ACC_W-1:0]  terms [N_PROD];
   logic signed [ACC_W-1:0]  acc_sum;
   logic signed [RND_W-1:0]  rounded;

   // Current input tap
   assign prod[0]  = coef.b0 * x;
   assign terms[0] = ACC_W'(prod[0]);

   // Past input and past output taps; feedback terms are subtracted
   for (genvar k = 0; k < FILTER_ORDER; k++) begin : g_tap
      assign prod[2*k+1]  = tap_num(coef, k + 1) * x_hist[k];
      assign prod[2*k+2]  = tap_den(coef, k + 1) * y_hist[k];
      assign terms[2*k+1] = ACC_W'(prod[2*k+1]);
      assign terms[2*k+2] = -ACC_W'(prod[2*k+2]);
   end

   // Sum all terms with the half-LSB rounding offset
   always_comb begin
      acc_sum = ROUND_HALF;
      for (int i = 0; i < N_PROD; i++) begin
         acc_sum = acc_sum + terms[i];
      end
   end

   // Drop the fraction, then clamp to the sample range
   assign rounded = RND_W'(acc_sum >>> FRAC_SHIFT);

   always_comb begin
      if (rounded > SAT_HI) begin
         y = SAMPLE_MAX;
      end else if (rounded < SAT_LO) begin
         y = SAMPLE_MIN;
      end else begin
         y = SAMPLE_W'(rounded);
      end
   end

endmodule

// ===== rtl/core/second_order_iir_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_order_iir_filter
// Direct form I biquad: y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  carries one signed Q16.16 sample per transfer (sample_in).
//   rsp_ch  returns one signed Q16.16 filtered sample per input transfer
//           (sample_out), rounded to nearest (ties up) and saturated.
//   csr_ch  writes the Q2.30 coefficients: index 0..4 = b0, b1, b2, a1, a2.
//           Writes to other indexes are dropped. Write only while idle.
// Path: an input transfer loads the input register; the sample is then
//   evaluated into the result register, which drives rsp_ch.valid.
// Throughput: one sample per cycle while rsp_ch.ready stays high. The limit
//   is the feedback loop from the output history through five parallel 32x32
//   multipliers, the wide adder and round/saturate logic back into the history.
// Reset: coefficients and the input and output history clear to zero; both
//   pipeline stages empty.
// Stall: while rsp_ch.ready is low the result register holds; one more
//   sample can be taken into the input register, then req_ch.ready drops
//   until the result is taken.
// ----------------------------------------------------------------------------
module second_order_iir_filter import sofif_pkg::*; #(
   parameter int FILTER_ORDER = FILTER_ORDER_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sofif_req_if.sink   req_ch,
   sofif_rsp_if.source rsp_ch,
   sofif_csr_if.sink   csr_ch
);

   coef_type   coef;
   logic       req_fire;
   logic       advance;

   logic       x_valid_ff;
   logic       x_valid_in;
   sample_type x_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   sample_type y_ff;
   sample_type y_new;

   sample_type x_hist_ff [FILTER_ORDER];
   sample_type x_hist_in [FILTER_ORDER];
   sample_type y_hist_ff [FILTER_ORDER];
   sample_type y_hist_in [FILTER_ORDER];

   sofif_coef_regs u_coef_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .coef   (coef)
   );

   sofif_mac #(
      .FILTER_ORDER (FILTER_ORDER)
   ) u_mac (
      .coef   (coef),
      .x      (x_ff),
      .x_hist (x_hist_ff),
      .y_hist (y_hist_ff),
      .y      (y_new)
   );

   // Handshake: move the held sample on when the result register frees up
   assign advance      = x_valid_ff & (~rsp_valid_ff | rsp_ch.ready);
   assign req_ch.ready = ~x_valid_ff | advance;
   assign req_fire     = req_ch.valid & req_ch.ready;

   assign x_valid_in   = req_fire ? 1'b1 : (advance ? 1'b0 : x_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
      end else begin
         x_valid_ff <= x_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff <= req_ch.sample_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         y_ff <= y_new;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sample_out = y_ff;

   // Shift the history by one tap on each evaluated sample
   always_comb begin
      x_hist_in = x_hist_ff;
      y_hist_in = y_hist_ff;
      if (advance) begin
         for (int k = FILTER_ORDER - 1; k > 0; k--) begin
            x_hist_in[k] = x_hist_ff[k-1];
            y_hist_in[k] = y_hist_ff[k-1];
         end
         x_hist_in[0] = x_ff;
         y_hist_in[0] = y_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < FILTER_ORDER; k++) begin
            x_hist_ff[k] <= '0;
            y_hist_ff[k] <= '0;
         end
      end else begin
         x_hist_ff <= x_hist_in;
         y_hist_ff <= y_hist_in;
      end
   end

   // An evaluated sample always lands in the result register
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result register empty after an evaluated sample");

   // A taken sample always lands in the input register
   a_fire_fills_x: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> x_valid_ff)
      else $error("input register empty after a request transfer");

   // A held sample that does not advance keeps its value
   a_x_holds: assert property (@(posedge clock) disable iff (reset)
      (x_valid_ff && !advance) |=> (x_valid_ff && $stable(x_ff)))
      else $error("held sample lost or changed while stalled");

   // The newest history entries are the sample just evaluated and its result
   a_hist_tracks_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> (y_hist_ff[0] == y_ff && x_hist_ff[0] == $past(x_ff)))
      else $error("history out of step with the result register");

endmodule

// ===== bench/second_order_iir_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_order_iir_filter_tb
// Self-checking bench for the direct form I biquad filter.
// A directed table covers reset state, saturation at both rails, round-half-up
// ties and dropped register writes. Random phases then load new coefficient
// sets while idle and stream samples under sender gaps and receiver stalls.
// Every result is checked against a bit-exact wide-accumulator predictor.
// ----------------------------------------------------------------------------
module second_order_iir_filter_tb import sofif_pkg::*; ();

   localparam int LIMIT_CYCLES   = 300000;
   localparam int RESET_CYCLES   = 12;
   localparam int NUM_PHASES     = 24;
   localparam int PHASE_ITEMS    = 76;
   localparam int LONG_HOLD      = 400;
   localparam int MAX_PRINTS     = 40;
   localparam int PRESSURE_PHASE = 6;
   localparam int PAUSE_PHASE    = 9;

   // Index past the register set; writes to it are dropped
   localparam csr_index_type REG_UNUSED = 3'd7;

   // Accumulator wide enough for five Q18.46 products without wrap
   typedef logic signed [69:0] acc_type;
   // Half of one output LSB, for round-half-up
   localparam acc_type ROUND_HALF = 70'sd1 <<< (FRAC_SHIFT - 1);

   typedef enum logic {OP_SAMPLE, OP_WRITE} step_op_type;

   typedef struct packed {
      step_op_type   op;
      csr_index_type idx;
      logic [31:0]   data;
      logic          typed;
      logic [31:0]   want;
   } directed_row_type;

   logic clock;
   logic reset;

   sofif_req_if req_ch ();
   sofif_rsp_if rsp_ch ();
   sofif_csr_if csr_ch ();

   second_order_iir_filter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predictor state: coefficients and history
   coef_type   model_coef;
   sample_type hist_x1, hist_x2, hist_y1, hist_y2;

   sample_type expected_out [$];

   int mismatches      = 0;
   int results_checked = 0;
   int samples_sent    = 0;
   int coef_writes     = 0;
   int cycle_count     = 0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_request  = 0;
   int hold_left     = 0;

   directed_row_type plan [36] = '{
      // coefficients are zero after reset
      '{OP_SAMPLE, REG_B0, SAMPLE_MAX,   1'b1, 32'h0000_0000},
      '{OP_SAMPLE, REG_B0, SAMPLE_MIN,   1'b1, 32'h0000_0000},
      // unity gain passes samples through
      '{OP_WRITE,  REG_B0, 32'h4000_0000, 1'b0, 32'h0},
      '{OP_SAMPLE, REG_B0, SAMPLE_MAX,   1'b1, SAMPLE_MAX},
      '{OP_SAMPLE, REG_B0, SAMPLE_MIN,   1'b1, SAMPLE_MIN},
      '{OP_SAMPLE, REG_B0, 32'h0000_0001, 1'b1, 32'h0000_0001},
      '{OP_SAMPLE, REG_B0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      // largest positive gain saturates both rails
      '{OP_WRITE,  REG_B0, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{OP_SAMPLE, REG_B0, SAMPLE_MAX,   1'b1, SAMPLE_MAX},
      '{OP_SAMPLE, REG_B0, SAMPLE_MIN,   1'b1, SAMPLE_MIN},
      // most negative gain flips the rails
      '{OP_WRITE,  REG_B0, 32'h8000_0000, 1'b0, 32'h0},
      '{OP_SAMPLE, REG_B0, SAMPLE_MIN,   1'b1, SAMPLE_MAX},
      '{OP_SAMPLE, REG_B0, SAMPLE_MAX,   1'b1, SAMPLE_MIN},
      // half gain: exact ties round toward plus infinity
      '{OP_WRITE,  REG_B0, 32'h2000_0000, 1'b0, 32'h0},
      '{OP_SAMPLE, REG_B0, 32'h0000_0001, 1'b1, 32'h0000_0001},
      '{OP_SAMPLE, REG_B0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
      '{OP_SAMPLE, REG_B0, 32'h0000_0003, 1'b1, 32'h0000_0002},
      '{OP_SAMPLE, REG_B0, 32'hFFFF_FFFD, 1'b1, 32'hFFFF_FFFF},
      // write past the register set is dropped, gain stays one half
      '{OP_WRITE,  REG_UNUSED, 32'h4000_0000, 1'b0, 32'h0},
      '{OP_SAMPLE, REG_B0, 32'h0000_0003, 1'b1, 32'h0000_0002},
      // full biquad with feedback
      '{OP_WRITE,  REG_B1, 32'h4000_0000, 1'b0, 32'h0},
      '{OP_WRITE,  REG_B2, 32'hC000_0000, 1'b0, 32'h0},
      '{OP_WRITE,  REG_A1, 32'h2000_0000, 1'b0, 32'h0},
      '{OP_WRITE,  REG_A2, 32'h1000_0000, 1'b0, 32'h0},
      '{OP_SAMPLE, REG_B0, 32'h0001_0000, 1'b0, 32'h0},
      '{OP_SAMPLE, REG_B0, 32'hFFFF_0000, 1'b0, 32'h0},
      '{OP_SAMPLE, REG_B0, 32'h1234_5678, 1'b0, 32'h0},
      '{OP_SAMPLE, REG_B0, SAMPLE_MAX,   1'b0, 32'h0},
      '{OP_SAMPLE, REG_B0, SAMPLE_MIN,   1'b0, 32'h0},
      '{OP_SAMPLE, REG_B0, 32'h0000_0000, 1'b0, 32'h0},
      // extreme feedback coefficients
      '{OP_WRITE,  REG_A1, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{OP_WRITE,  REG_A2, 32'h8000_0000, 1'b0, 32'h0},
      '{OP_SAMPLE, REG_B0, 32'h0001_0000, 1'b0, 32'h0},
      '{OP_SAMPLE, REG_B0, SAMPLE_MIN,   1'b0, 32'h0},
      '{OP_SAMPLE, REG_B0, SAMPLE_MAX,   1'b0, 32'h0},
      '{OP_SAMPLE, REG_B0, 32'h0000_0000, 1'b0, 32'h0}
   };

   // Sign-extend a 32-bit word into the accumulator width
   function automatic acc_type to_acc(input logic signed [31:0] v);
      acc_type r;
      r = v;
      return r;
   endfunction

   // Compute the next filtered sample and advance the history
   function automatic sample_type biquad_next(input sample_type x);
      acc_type    sum;
      acc_type    scaled;
      sample_type y;
      sum = to_acc(model_coef.b0) * to_acc(x)
          + to_acc(model_coef.b1) * to_acc(hist_x1)
          + to_acc(model_coef.b2) * to_acc(hist_x2)
          - to_acc(model_coef.a1) * to_acc(hist_y1)
          - to_acc(model_coef.a2) * to_acc(hist_y2)
          + ROUND_HALF;
      scaled = sum >>> FRAC_SHIFT;
      if (scaled > to_acc(SAMPLE_MAX)) begin
         y = SAMPLE_MAX;
      end else if (scaled < to_acc(SAMPLE_MIN)) begin
         y = SAMPLE_MIN;
      end else begin
         y = scaled[SAMPLE_W-1:0];
      end
      hist_x2 = hist_x1;
      hist_x1 = x;
      hist_y2 = hist_y1;
      hist_y1 = y;
      return y;
   endfunction

   function automatic sample_type rand_sample();
      sample_type s;
      case ($urandom_range(9))
         0:       s = SAMPLE_MAX;
         1:       s = SAMPLE_MIN;
         2, 3:    s = sample_type'($urandom_range(2097152)) - sample_type'(1048576);
         default: s = $urandom;
      endcase
      return s;
   endfunction

   function automatic coef_word_type rand_coef();
      coef_word_type c;
      case ($urandom_range(7))
         0:          c = 32'h7FFF_FFFF;
         1:          c = 32'h8000_0000;
         2:          c = '0;
         3, 4, 5:    c = coef_word_type'($urandom_range(536870912)) - coef_word_type'(268435456);
         default:    c = $urandom;
      endcase
      return c;
   endfunction

   task automatic report_mismatch(input string what, input sample_type got,
                                  input sample_type want);
      mismatches++;
      if (mismatches <= MAX_PRINTS) begin
         $display("[%0t] MISMATCH #%0d %s: got %08h want %08h", $realtime, mismatches,
                  what, got, want);
      end
   endtask

   // Offer one sample, with random idle gaps, and queue its expected result
   task automatic send_sample(input sample_type s, input logic typed, input sample_type want);
      bit         taken;
      sample_type y;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.sample_in <= s;
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ch.ready;
         if (taken) begin
            y = biquad_next(s);
            expected_out.push_back(typed ? want : y);
            samples_sent++;
         end
         @(posedge clock);
      end
   endtask

   // Write one register; valid stays high so writes can go back to back
   task automatic write_coef(input csr_index_type idx, input coef_word_type val);
      bit taken;
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= val;
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_ch.ready;
         @(posedge clock);
      end
      coef_writes++;
      case (idx)
         REG_B0:  model_coef.b0 = val;
         REG_B1:  model_coef.b1 = val;
         REG_B2:  model_coef.b2 = val;
         REG_A1:  model_coef.a1 = val;
         REG_A2:  model_coef.a2 = val;
         default: ;
      endcase
   endtask

   task automatic drain_results();
      while (expected_out.size() != 0) @(posedge clock);
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_out.size());
      $display("end of test: mismatches");
      $finish;
   end

   // Receiver: random stalls, plus long hold-offs on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Check each result transfer against the oldest expectation
   initial begin
      sample_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            results_checked++;
            if (expected_out.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_ch.sample_out, '0);
            end else begin
               want = expected_out.pop_front();
               if (rsp_ch.sample_out !== want) begin
                  report_mismatch("sample_out", rsp_ch.sample_out, want);
               end
            end
         end
      end
   end

   // Stimulus
   initial begin
      coef_word_type val;
      int            mode;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.sample_in <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= '0;
      csr_ch.wdata     <= '0;
      model_coef = '0;
      hist_x1    = '0;
      hist_x2    = '0;
      hist_y1    = '0;
      hist_y2    = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (plan[r]) begin
         if (plan[r].op == OP_WRITE) begin
            req_ch.valid <= 1'b0;
            drain_results();
            write_coef(plan[r].idx, plan[r].data);
         end else begin
            csr_ch.valid <= 1'b0;
            send_sample(plan[r].data, plan[r].typed, plan[r].want);
         end
      end
      req_ch.valid <= 1'b0;
      csr_ch.valid <= 1'b0;
      drain_results();

      // Random phases: new coefficients while idle, then a sample stream
      for (int p = 0; p < NUM_PHASES; p++) begin
         mode = p % 4;
         send_idle_pct = (mode == 1) ? 52 : (mode == 3) ? 27 : 0;
         rsp_stall_pct = (mode == 2) ? 52 : (mode == 3) ? 27 : 0;
         for (int r = 0; r < 5; r++) begin
            if (p == 1) begin
               val = 32'h7FFF_FFFF;
            end else if (p == 2) begin
               val = 32'h8000_0000;
            end else begin
               val = rand_coef();
            end
            write_coef(csr_index_type'(r), val);
         end
         // a stray write past the register set
         write_coef(csr_index_type'($urandom_range(5, 7)), $urandom);
         csr_ch.valid <= 1'b0;
         if (p == PRESSURE_PHASE) hold_request = LONG_HOLD;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == PAUSE_PHASE && i == PHASE_ITEMS / 2) begin
               // hold the sender until every result is back
               req_ch.valid <= 1'b0;
               drain_results();
            end
            send_sample(rand_sample(), 1'b0, '0);
         end
         req_ch.valid <= 1'b0;
         drain_results();
      end

      // Let the pipeline settle and catch any stray result
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (8) @(posedge clock);

      $display("covered %0d samples and %0d register writes over %0d random settings",
               samples_sent, coef_writes, NUM_PHASES);
      $display("results checked: %0d, mismatches: %0d, cycles: %0d", results_checked,
               mismatches, cycle_count);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/sofif_pkg.sv
rtl/core/sofif_intf.sv
rtl/core/sofif_coef_regs.sv
rtl/core/sofif_mac.sv
rtl/core/second_order_iir_filter.sv
bench/second_order_iir_filter_tb.sv
